[rtl/rsrf_pkg.sv]
package rsrf_pkg;

   localparam int DEF_CAPACITY = 16;
   localparam int DEF_KEY_BITS = 32;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ASCENDING      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES_IN_USE = 2'd1;

   localparam logic KIND_KEY   = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

endpackage

[rtl/replacement_selection_run_former.sv]
// Replacement-selection run former.
// Input words (req_) carry kind and key: a key, or an end-of-stream flush.
// Result words (rsp_) carry out_key, new_run and last. Configuration words
// (csr_) write the sort direction (index 0) and the store size (index 1);
// csr_ready is high only while the block is idle, so writes land between items.
// Keys sit in a synchronous memory of CAPACITY entries; occupied and
// next-run marks are flip-flops. Every search walks the memory one entry per
// cycle. A key that fills the store is written while idle, with no search; a
// replacing key goes through walk, last read, decide and write back; a flush
// walks the store anew for each stored key, over two passes.
// One item is worked on at a time; req_ready is high only while idle.
// The result register parts the two channels: a new item is taken while a
// result still waits. If rsp_ready stays low, the block holds in its decide
// step until the register frees. Reset empties the store, closes the run and
// sets ascending order with a store size of 16; the memory itself needs no
// clearing pass.
module replacement_selection_run_former
   import rsrf_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY,
   parameter int KEY_BITS = DEF_KEY_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic [31:0]          req_key,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_out_key,
   output logic                 rsp_new_run,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (FILL_W > 5) ? FILL_W : 5;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_TAIL, ST_DECIDE} state_type;

   state_type              state_ff;
   logic                   ascending_ff;
   logic [4:0]             entries_in_use_ff;
   logic [CAPACITY-1:0]    occ_ff;
   logic [CAPACITY-1:0]    next_run_ff;
   logic [CAPACITY-1:0]    taken_ff;
   logic [FILL_W-1:0]      fill_count_ff;
   logic                   run_open_ff;
   logic                   flush_ff;
   logic                   pass_ff;
   logic                   first_ff;
   logic [KEY_BITS-1:0]    key_hold_ff;
   logic [IDX_W-1:0]       scan_idx_ff;
   logic                   rd_valid_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic [KEY_BITS-1:0]    rd_data_ff;
   logic                   best_valid_ff;
   logic [IDX_W-1:0]       best_idx_ff;
   logic [KEY_BITS-1:0]    best_key_ff;
   logic                   rsp_valid_ff;
   logic [31:0]            rsp_out_key_ff;
   logic                   rsp_new_run_ff;
   logic                   rsp_last_ff;

   logic [KEY_BITS-1:0]    mem [CAPACITY];

   logic [KEY_BITS-1:0]    key_in;
   logic [CMP_W-1:0]       size_in;
   logic                   can_fill;
   logic                   req_take;
   logic                   out_free;
   logic                   emit_word;
   logic                   cand;
   logic                   better;
   logic                   joins;
   logic [CAPACITY-1:0]    next_run_upd;
   logic                   any_current;
   logic [CAPACITY-1:0]    best_onehot;
   logic                   flush_last;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_wa;
   logic [KEY_BITS-1:0]    mem_wd;

   assign key_in    = KEY_BITS'(req_key);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_word = (state_ff == ST_DECIDE) && best_valid_ff && out_free;

   always_comb begin
      if (entries_in_use_ff == 5'd0) begin
         size_in = CMP_W'(1);
      end else if (CMP_W'(entries_in_use_ff) > CMP_W'(CAPACITY)) begin
         size_in = CMP_W'(CAPACITY);
      end else begin
         size_in = CMP_W'(entries_in_use_ff);
      end
   end
   assign can_fill = CMP_W'(fill_count_ff) < size_in;

   assign cand = occ_ff[rd_idx_ff] && (next_run_ff[rd_idx_ff] == pass_ff)
                 && !taken_ff[rd_idx_ff];
   assign better = ascending_ff ? (rd_data_ff < best_key_ff) : (rd_data_ff > best_key_ff);
   assign joins  = ascending_ff ? (best_key_ff < key_hold_ff) : (best_key_ff > key_hold_ff);

   always_comb begin
      best_onehot = '0;
      best_onehot[best_idx_ff] = 1'b1;
      next_run_upd = next_run_ff;
      next_run_upd[best_idx_ff] = !joins;
   end
   assign any_current = |(occ_ff & ~next_run_upd);
   assign flush_last  = ((occ_ff & ~taken_ff & ~best_onehot) == '0);

   always_comb begin
      mem_we = 1'b0;
      mem_wa = fill_count_ff[IDX_W-1:0];
      mem_wd = key_in;
      if (req_take && req_kind == KIND_KEY && can_fill) begin
         mem_we = 1'b1;
      end else if (state_ff == ST_DECIDE && !flush_ff && best_valid_ff && out_free) begin
         mem_we = 1'b1;
         mem_wa = best_idx_ff;
         mem_wd = key_hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[scan_idx_ff];
      rd_idx_ff  <= scan_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         ascending_ff      <= 1'b1;
         entries_in_use_ff <= 5'd16;
         occ_ff            <= '0;
         next_run_ff       <= '0;
         taken_ff          <= '0;
         fill_count_ff     <= '0;
         run_open_ff       <= 1'b0;
         flush_ff          <= 1'b0;
         pass_ff           <= 1'b0;
         first_ff          <= 1'b0;
         scan_idx_ff       <= '0;
         rd_valid_ff       <= 1'b0;
         best_valid_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ASCENDING:      ascending_ff      <= csr_data[0];
               CSR_ENTRIES_IN_USE: entries_in_use_ff <= csr_data[4:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && !emit_word) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_valid_ff <= (state_ff == ST_SCAN);
         if (rd_valid_ff && cand && (!best_valid_ff || better)) begin
            best_valid_ff <= 1'b1;
            best_idx_ff   <= rd_idx_ff;
            best_key_ff   <= rd_data_ff;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  key_hold_ff   <= key_in;
                  taken_ff      <= '0;
                  pass_ff       <= 1'b0;
                  first_ff      <= 1'b1;
                  scan_idx_ff   <= '0;
                  best_valid_ff <= 1'b0;
                  if (req_kind == KIND_FLUSH) begin
                     flush_ff <= 1'b1;
                     state_ff <= ST_SCAN;
                  end else if (can_fill) begin
                     occ_ff[fill_count_ff[IDX_W-1:0]]      <= 1'b1;
                     next_run_ff[fill_count_ff[IDX_W-1:0]] <= 1'b0;
                     fill_count_ff <= fill_count_ff + 1'b1;
                  end else begin
                     flush_ff <= 1'b0;
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (scan_idx_ff == IDX_W'(CAPACITY - 1)) begin
                  state_ff <= ST_TAIL;
               end else begin
                  scan_idx_ff <= scan_idx_ff + 1'b1;
               end
            end
            ST_TAIL: begin
               scan_idx_ff <= '0;
               state_ff    <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (!flush_ff) begin
                  if (!best_valid_ff) begin
                     state_ff <= ST_IDLE;
                  end else if (out_free) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_out_key_ff <= 32'(best_key_ff);
                     rsp_new_run_ff <= !run_open_ff;
                     rsp_last_ff    <= 1'b1;
                     if (any_current) begin
                        next_run_ff <= next_run_upd;
                        run_open_ff <= 1'b1;
                     end else begin
                        next_run_ff <= '0;
                        run_open_ff <= 1'b0;
                     end
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  if (best_valid_ff) begin
                     if (out_free) begin
                        rsp_valid_ff   <= 1'b1;
                        rsp_out_key_ff <= 32'(best_key_ff);
                        rsp_new_run_ff <= first_ff && (pass_ff || !run_open_ff);
                        rsp_last_ff    <= flush_last;
                        first_ff       <= 1'b0;
                        taken_ff[best_idx_ff] <= 1'b1;
                        best_valid_ff  <= 1'b0;
                        state_ff       <= ST_SCAN;
                     end
                  end else if (!pass_ff) begin
                     pass_ff  <= 1'b1;
                     first_ff <= 1'b1;
                     state_ff <= ST_SCAN;
                  end else begin
                     occ_ff        <= '0;
                     next_run_ff   <= '0;
                     taken_ff      <= '0;
                     fill_count_ff <= '0;
                     run_open_ff   <= 1'b0;
                     state_ff      <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_key = rsp_out_key_ff;
   assign rsp_new_run = rsp_new_run_ff;
   assign rsp_last    = rsp_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(fill_count_ff) <= CMP_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_winner_occupied: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && best_valid_ff) |-> occ_ff[best_idx_ff])
      else $error("winner entry not occupied");

   a_taken_subset: assert property (@(posedge clock) disable iff (reset)
      (taken_ff & ~occ_ff) == '0)
      else $error("taken mark on empty entry");

   a_emit_frees: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && !flush_ff && best_valid_ff && out_free)
      |=> (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("replacement did not emit its word");

endmodule
